[hdl/ps2md_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types, constants and helpers for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BTN_W     = 3;
  localparam int unsigned MOVE_W    = 8;
  localparam int unsigned WHEEL_W   = 5;
  localparam int unsigned POS_W     = 2;
  localparam int unsigned PKT_DEPTH = 3;

  // bit positions inside byte 0 of a packet
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned X_SIGN_BIT = 4;
  localparam int unsigned Y_SIGN_BIT = 5;

  // byte positions within a packet
  localparam logic [POS_W-1:0] POS_FIRST = 2'd0;
  localparam logic [POS_W-1:0] POS_THIRD = 2'd2;
  localparam logic [POS_W-1:0] POS_WHEEL = 2'd3;

  localparam logic signed [MOVE_W-1:0] SAT_HIGH = 8'sd127;
  localparam logic signed [MOVE_W-1:0] SAT_LOW  = -8'sd127;

  // result word, buttons in the low bits
  typedef struct packed {
    logic signed [WHEEL_W-1:0] wheel_step;
    logic signed [MOVE_W-1:0]  move_y;
    logic signed [MOVE_W-1:0]  move_x;
    logic [BTN_W-1:0]          buttons;
  } ps2md_res_t;

  localparam int unsigned RES_W = $bits(ps2md_res_t);

  // per-byte control decisions from the decoder
  typedef struct packed {
    logic accept_byte;  // byte passes the sync check
    logic advance;      // more bytes to come in this packet
    logic emit;         // packet complete and reportable
  } ps2md_step_t;

  // clamp a 10-bit motion value to +/-127
  function automatic logic signed [MOVE_W-1:0] sat127(input logic signed [9:0] v);
    logic signed [MOVE_W-1:0] r;
    if (v > 10'sd127) begin
      r = SAT_HIGH;
    end else if (v < -10'sd127) begin
      r = SAT_LOW;
    end else begin
      r = v[MOVE_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/ps2md_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2md_decode
// Per-byte decision and packet decode: sync check, completion, motion and
// wheel extraction, event suppression and saturation.
// ----------------------------------------------------------------------------
module ps2md_decode (
  input  logic [7:0]               data_byte,
  input  logic [1:0]               pos,
  input  logic                     wheel_mode,
  input  logic [2:0]               last_buttons,
  input  logic [7:0]               pkt_b0,
  input  logic [7:0]               pkt_b1,
  input  logic [7:0]               pkt_b2,
  output ps2md_pkg::ps2md_step_t   step,
  output ps2md_pkg::ps2md_res_t    res
);
  import ps2md_pkg::*;

  logic [BYTE_W-1:0]         b2;
  logic signed [9:0]         dx;
  logic signed [9:0]         dy_raw;
  logic signed [9:0]         dy;
  logic signed [WHEEL_W-1:0] wheel;
  logic                      four_byte;
  logic                      sync_ok;
  logic                      advance;
  logic                      idle_pkt;

  // third byte is still on the input when a three-byte packet closes
  assign b2 = (pos == POS_THIRD) ? data_byte : pkt_b2;

  assign sync_ok = (pos != POS_FIRST) || data_byte[SYNC_BIT];
  assign advance = (pos < POS_THIRD) || ((pos == POS_THIRD) && wheel_mode);

  assign dx     = {pkt_b0[X_SIGN_BIT], pkt_b0[X_SIGN_BIT], pkt_b1};
  assign dy_raw = {pkt_b0[Y_SIGN_BIT], pkt_b0[Y_SIGN_BIT], b2};
  assign dy     = -dy_raw;

  // mode dropped mid-packet: fourth byte closes as a plain three-byte packet
  assign four_byte = (pos == POS_WHEEL) && wheel_mode;
  assign wheel = four_byte ? -$signed({data_byte[3], data_byte[3:0]}) : '0;

  assign idle_pkt = (pkt_b0[BTN_W-1:0] == last_buttons) && (dx == 10'sd0)
                    && (dy == 10'sd0) && (wheel == '0);

  assign step.accept_byte = sync_ok;
  assign step.advance     = advance;
  assign step.emit        = sync_ok && !advance && !idle_pkt;

  assign res.buttons    = pkt_b0[BTN_W-1:0];
  assign res.move_x     = sat127(dx);
  assign res.move_y     = sat127(dy);
  assign res.wheel_step = wheel;

endmodule

[hdl/ps2_mouse_packet_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_top
// PS/2 mouse stream decoder: gathers 3- or 4-byte packets and emits button,
// motion and wheel events on a stream output.
// ----------------------------------------------------------------------------
// events are registered in out_r, or in the skid word while out_r is stalled
// throughput: one byte per cycle while in_tready is high; the decode is a
//   single pass of logic between the byte handshake and the output register
// a two-word output stage (output register plus skid) keeps in_tready up
//   while one event waits; in_tready is low only when both words are held
// reset (rst_n low, synchronous) clears byte position, last buttons, wheel
//   mode and output valids; stored packet bytes are not cleared
module ps2_mouse_packet_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: bit 0 = wheel_mode
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // byte stream in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  // event stream out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] buttons, [10:3] move_x,
                                  // [18:11] move_y, [23:19] wheel_step
);
  import ps2md_pkg::*;

  // packet state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BTN_W-1:0]  last_btn_r, last_btn_nxt;
  logic              wheel_mode_r;
  logic [BYTE_W-1:0] pkt_r [PKT_DEPTH];

  // output stage
  ps2md_res_t out_r, out_nxt;
  ps2md_res_t skid_r, skid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;

  ps2md_step_t step;
  ps2md_res_t  res;
  logic        in_fire;
  logic        res_valid;
  logic        main_free;

  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  ps2md_decode u_decode (
    .data_byte    (in_tdata),
    .pos          (pos_r),
    .wheel_mode   (wheel_mode_r),
    .last_buttons (last_btn_r),
    .pkt_b0       (pkt_r[0]),
    .pkt_b1       (pkt_r[1]),
    .pkt_b2       (pkt_r[2]),
    .step         (step),
    .res          (res)
  );

  assign res_valid = in_fire && step.emit;

  // byte position and last reported buttons
  always_comb begin
    pos_nxt      = pos_r;
    last_btn_nxt = last_btn_r;
    if (in_fire && step.accept_byte) begin
      if (step.advance) begin
        pos_nxt = pos_r + 2'd1;
      end else begin
        pos_nxt = POS_FIRST;  // packet closed
      end
    end
    if (res_valid) begin
      last_btn_nxt = res.buttons;
    end
  end

  // output register with skid word behind it
  assign main_free = !out_valid_r || out_tready;

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (main_free) begin
      if (skid_valid_r) begin
        // skid drains first; no byte was taken this cycle
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      // consumer stalled: park the new event
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_FIRST;
      last_btn_r   <= '0;
      wheel_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      last_btn_r   <= last_btn_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_wr_en) begin
        wheel_mode_r <= cfg_wr_data;
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (in_fire && step.accept_byte && (pos_r != POS_WHEEL)) begin
      pkt_r[pos_r] <= in_tdata;
    end
  end

  // skid word is only ever held behind a full output register
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  // skid only fills when the output word is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid filled while output register was free");

  // saturation never yields -128
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.move_x != 8'h80) && (out_r.move_y != 8'h80)))
    else $error("motion not saturated to +/-127");

  // fourth byte position only reachable through wheel mode
  assert property (@(posedge clk) disable iff (!rst_n)
    ((pos_r == POS_WHEEL) && ($past(pos_r) != POS_WHEEL)) |-> $past(wheel_mode_r))
    else $error("fourth byte position entered without wheel mode");

endmodule

[dv/ps2_mouse_packet_decoder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_top_tb
// Self-checking bench for the PS/2 mouse packet decoder. A queue-fed driver
// streams raw mouse bytes, a bit-accurate packet tracker predicts each event,
// and a monitor compares every event word field by field. Runs cover both
// packet lengths, mode changes in the middle of a packet, resync on bad
// bytes, saturation, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_top_tb;
  import ps2md_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned IDLE_PCT     = 18;
  localparam int unsigned MAX_REPORTS  = 10;

  // two's complement offset of the 9-bit motion values
  localparam logic signed [9:0] NINE_BIT_OFS = 10'sd256;
  localparam logic [7:0]        NIBBLE_MASK  = 8'h0F;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // block inputs, all known from time zero
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [7:0]  in_tdata    = '0;
  logic        out_tready  = 1'b0;

  // block outputs
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;   // [2:0] buttons, [10:3] move_x,
                            // [18:11] move_y, [23:19] wheel_step

  // stimulus and scoreboard storage
  logic [7:0]  byte_q[$];            // raw stream bytes not yet accepted
  ps2md_res_t  expected_events[$];   // predicted event words, oldest first
  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;

  // phase controls, written by the sequencer at the falling edge only
  bit idle_en  = 1'b1;
  bit stall_go = 1'b0;

  // packet tracker state, mirrors the block's own
  logic [POS_W-1:0] pos_m      = POS_FIRST;
  logic [7:0]       pkt_m[PKT_DEPTH];
  logic [BTN_W-1:0] last_btn_m = '0;
  bit               wheel_m    = 1'b0;

  // generator memory so that repeated buttons show up often
  logic [BTN_W-1:0] gen_btn = '0;

  ps2_mouse_packet_decoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clamp a motion value into the +/-127 event range
  function automatic logic signed [MOVE_W-1:0] clamp_motion(input logic signed [9:0] v);
    logic signed [9:0] c;
    c = v;
    if (c > 10'sd127) c = 10'sd127;
    if (c < -10'sd127) c = -10'sd127;
    return c[MOVE_W-1:0];
  endfunction

  // advance the packet tracker by one accepted byte; queue an event if one results
  task automatic track_mouse_byte(input logic [7:0] b);
    logic [BTN_W-1:0]  btn;
    logic signed [9:0] dx;
    logic signed [9:0] dy;
    logic signed [9:0] whl;
    ps2md_res_t        ev;
    // a packet cannot open without the always-one bit, so the byte is dropped
    if (pos_m == POS_FIRST && !b[SYNC_BIT]) return;
    if (pos_m != POS_WHEEL) pkt_m[pos_m] = b;
    if (pos_m < POS_THIRD || (pos_m == POS_THIRD && wheel_m)) begin
      pos_m = pos_m + 2'd1;
      return;
    end
    // packet closes here; sign bits of x and y sit in byte 0
    btn = pkt_m[0][BTN_W-1:0];
    dx  = $signed({2'b00, pkt_m[1]}) - (pkt_m[0][X_SIGN_BIT] ? NINE_BIT_OFS : 10'sd0);
    dy  = (pkt_m[0][Y_SIGN_BIT] ? NINE_BIT_OFS : 10'sd0) - $signed({2'b00, pkt_m[2]});
    whl = 10'sd0;
    // fourth byte only counts while wheel mode is still on
    if (pos_m == POS_WHEEL && wheel_m) begin
      whl = $signed({{6{b[3]}}, b[3:0] & NIBBLE_MASK[3:0]});
      whl = -whl;
    end
    pos_m = POS_FIRST;
    // nothing changed, nothing reported
    if (btn == last_btn_m && dx == 0 && dy == 0 && whl == 0) return;
    last_btn_m    = btn;
    ev.buttons    = btn;
    ev.move_x     = clamp_motion(dx);
    ev.move_y     = clamp_motion(dy);
    ev.wheel_step = whl[WHEEL_W-1:0];
    expected_events.push_back(ev);
  endtask

  // byte driver: holds a word until accepted, idles at random between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_mouse_byte(in_tdata);
        void'(byte_q.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // word still waiting, keep it on the bus
      end else if (byte_q.size() != 0 &&
                   !(idle_en && $urandom_range(99) < IDLE_PCT)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= byte_q[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready: random backpressure, plus one long hold when asked
  int unsigned stall_left = 0;
  bit          stall_seen = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_go && !stall_seen) stall_left = STALL_CYCLES;
      stall_seen = stall_go;
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_tready <= 1'b0;
      end else if (idle_en) begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // count and, for the first few, print a bad event
  task automatic flag_event(input string what, input ps2md_res_t exp_ev,
                            input ps2md_res_t got_ev);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t %s: exp btn=%0d x=%0d y=%0d w=%0d got btn=%0d x=%0d y=%0d w=%0d",
               $realtime, what, exp_ev.buttons, exp_ev.move_x, exp_ev.move_y,
               exp_ev.wheel_step, got_ev.buttons, got_ev.move_x, got_ev.move_y,
               got_ev.wheel_step);
  endtask

  // event monitor: each accepted word against the oldest prediction
  always @(posedge clk) begin
    ps2md_res_t got_ev;
    ps2md_res_t exp_ev;
    if (rst_n && out_tvalid && out_tready) begin
      got_ev = ps2md_res_t'(out_tdata);
      if (expected_events.size() == 0) begin
        exp_ev = '0;
        flag_event("unexpected event", exp_ev, got_ev);
      end else begin
        exp_ev = expected_events.pop_front();
        if (got_ev.buttons !== exp_ev.buttons || got_ev.move_x !== exp_ev.move_x ||
            got_ev.move_y !== exp_ev.move_y || got_ev.wheel_step !== exp_ev.wheel_step)
          flag_event("event mismatch", exp_ev, got_ev);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // register write while the block is idle; tracker follows at the same time
  task automatic set_wheel_mode(input bit mode);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    wheel_m      = mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // sender pause: all bytes taken, all events seen, then let the pipe settle
  task automatic wait_idle();
    while (byte_q.size() != 0 || expected_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // 9-bit motion, weighted toward zero, small steps and the far ends
  function automatic logic [8:0] pick_motion();
    case ($urandom_range(9))
      0, 1, 2: return 9'd0;
      3, 4, 5: return 9'($urandom_range(16)) - 9'd8;
      6:       return 9'h100 + 9'($urandom_range(127));
      7:       return 9'd128 + 9'($urandom_range(127));
      default: return 9'($urandom);
    endcase
  endfunction

  // queue the first n_keep bytes of a well-formed packet with random content
  task automatic push_packet(input bit four, input int unsigned n_keep);
    logic [7:0] pb[4];
    logic [8:0] mx;
    logic [8:0] my;
    logic [3:0] nib;
    if ($urandom_range(9) < 3) gen_btn = 3'($urandom_range(7));
    mx  = pick_motion();
    my  = pick_motion();
    nib = 4'($urandom_range(15));
    // quiet packets exercise the no-change suppression
    if ($urandom_range(4) == 0) begin
      mx  = '0;
      my  = '0;
      nib = '0;
    end
    pb[0] = {2'($urandom_range(3)), my[8], mx[8], 1'b1, gen_btn};
    pb[1] = mx[7:0];
    pb[2] = my[7:0];
    pb[3] = {4'($urandom_range(15)), nib};
    for (int unsigned i = 0; i < (four ? 4 : 3) && i < n_keep; i++) byte_q.push_back(pb[i]);
  endtask

  // mostly whole packets for the current mode, some noise and broken packets
  task automatic run_random(input int unsigned n_bytes);
    int unsigned start_len;
    int unsigned r;
    start_len = byte_q.size();
    while (byte_q.size() - start_len < n_bytes) begin
      r = $urandom_range(99);
      if (r < 78) begin
        push_packet(wheel_m, 4);
      end else if (r < 84) begin
        push_packet(!wheel_m, 4);               // wrong length for the mode
      end else if (r < 91) begin
        byte_q.push_back(8'($urandom));         // stray byte
      end else if (r < 96) begin
        push_packet(wheel_m, $urandom_range(1, 2));  // lost tail
      end else begin
        byte_q.push_back(8'($urandom) & ~8'h08);     // cannot open a packet
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // three-byte mode: saturation at both ends, suppression, dropped bytes
    set_wheel_mode(1'b0);
    byte_q.push_back(8'h2F); byte_q.push_back(8'hFF); byte_q.push_back(8'h00);
    byte_q.push_back(8'h1D); byte_q.push_back(8'h00); byte_q.push_back(8'hFF);
    byte_q.push_back(8'h0D); byte_q.push_back(8'h00); byte_q.push_back(8'h00);
    byte_q.push_back(8'h00); byte_q.push_back(8'hF7);
    byte_q.push_back(8'hE8); byte_q.push_back(8'h01); byte_q.push_back(8'hFF);
    // two bytes of a packet left open across the mode change
    byte_q.push_back(8'h09); byte_q.push_back(8'h05);
    wait_idle();

    // wheel mode: open packet grows to four bytes, wheel steps of +8 and -7,
    // quiet wheel packet suppressed
    set_wheel_mode(1'b1);
    byte_q.push_back(8'h03); byte_q.push_back(8'h08);
    byte_q.push_back(8'h08); byte_q.push_back(8'h00); byte_q.push_back(8'h00);
    byte_q.push_back(8'h07);
    byte_q.push_back(8'h08); byte_q.push_back(8'h00); byte_q.push_back(8'h00);
    byte_q.push_back(8'hF0);
    // three bytes left open, closed after the switch back
    byte_q.push_back(8'h0A); byte_q.push_back(8'h10); byte_q.push_back(8'h20);
    wait_idle();

    // fourth byte lands with wheel mode off: decoded as three-byte packet
    set_wheel_mode(1'b0);
    byte_q.push_back(8'h5B);
    wait_idle();

    // random phases, alternating modes; partial packets cross the switches
    for (int unsigned ph = 0; ph < 6; ph++) begin
      set_wheel_mode(ph[0] ? 1'b0 : 1'b1);
      idle_en = (ph != 3);                      // one stretch with no idling
      run_random(230);
      wait_idle();
    end

    // long output hold while bytes keep coming: the block fills and stalls
    set_wheel_mode(1'b1);
    idle_en  = 1'b0;
    stall_go = 1'b1;
    for (int unsigned i = 0; i < 60; i++) push_packet(1'b1, 4);
    wait_idle();
    stall_go = 1'b0;
    idle_en  = 1'b1;

    // final settle
    repeat (DRAIN_CYCLES) @(negedge clk);
    err_cnt = err_cnt + expected_events.size();
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
